// ===== rtl/core/adsr_envelope_with_glide_unit_macros.svh =====
// Assertion macros for the ADSR envelope with glide unit.
// Included by the checker; depends on nothing else.
`ifndef ADSR_ENVELOPE_WITH_GLIDE_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_WITH_GLIDE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADSRG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("adsrg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADSRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("adsrg: next-cycle check failed");

`endif

// ===== rtl/core/adsrg_pkg.sv =====
// Shared types, widths, codes and constants of the ADSR envelope with glide unit.
// Used by every module of the block; depends on nothing.
package adsrg_pkg;

    // Fixed-point formats.
    localparam int COEF_FRAC_BITS = 24;
    localparam int AMP_FRAC_BITS  = 23;

    // Field widths.
    localparam int REG_W     = 24;
    localparam int FREQ_W    = 22;
    localparam int OUT_AMP_W = 24;
    localparam int OP_W      = 2;
    localparam int STAGE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Internal amplitude holds 0 .. 1.0 inclusive.
    localparam int AMP_W = AMP_FRAC_BITS + 1;
    // Common datapath width for amplitude, sustain and frequency values.
    localparam int VAL_W = (AMP_W > REG_W) ? AMP_W : REG_W;
    localparam int PROD_W = VAL_W + REG_W + 1;

    // Stream widths.
    localparam int S_TDATA_W = ((FREQ_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W;
    localparam int M_FIELD_W = OUT_AMP_W + FREQ_W + STAGE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Amplitude constants.
    localparam longint unsigned AMP_ONE_L   = 64'd1 << AMP_FRAC_BITS;
    localparam longint unsigned THR_SNAP_L  = (AMP_ONE_L + 500) / 1000;
    localparam longint unsigned THR_QUIET_L = (AMP_ONE_L + 5000) / 10000;
    localparam logic [VAL_W-1:0] AMP_ONE   = VAL_W'(AMP_ONE_L);
    localparam logic [VAL_W-1:0] THR_SNAP  = VAL_W'(THR_SNAP_L);
    localparam logic [VAL_W-1:0] THR_QUIET = VAL_W'(THR_QUIET_L);

    localparam logic [FREQ_W-1:0] RESET_FREQ = FREQ_W'(28160);

    // Register reset values.
    localparam logic [REG_W-1:0] RST_ATTACK_STEP = REG_W'(17476);
    localparam logic [REG_W-1:0] RST_DECAY_COEF  = REG_W'(1165);
    localparam logic [REG_W-1:0] RST_SUSTAIN     = REG_W'(5872026);
    localparam logic [REG_W-1:0] RST_RELEASE     = REG_W'(999);
    localparam logic [REG_W-1:0] RST_PITCH_RATE  = REG_W'(11651);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_RATE  = 3'd4;

    // Item kinds.
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [OP_W-1:0] OP_PANIC    = 2'd3;

    typedef logic [STAGE_W-1:0] t_stage;

    // Envelope stages.
    localparam t_stage ST_IDLE    = 3'd0;
    localparam t_stage ST_ATTACK  = 3'd1;
    localparam t_stage ST_DECAY   = 3'd2;
    localparam t_stage ST_SUSTAIN = 3'd3;
    localparam t_stage ST_RELEASE = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] attack_step;
        logic [REG_W-1:0] decay_coef;
        logic [REG_W-1:0] sustain_level;
        logic [REG_W-1:0] release_coef;
        logic [REG_W-1:0] pitch_rate;
    } t_cfg;

    typedef struct packed {
        logic [AMP_W-1:0]  amp;
        logic [FREQ_W-1:0] freq_now;
        logic [FREQ_W-1:0] freq_goal;
        t_stage            stage;
    } t_voice;

endpackage

// ===== rtl/core/adsrg_approach.sv =====
// Exponential approach step: moves a value toward a goal by a rounded,
// saturated fraction of the distance. Depends on adsrg_pkg.
module adsrg_approach (
    input  logic [adsrg_pkg::VAL_W-1:0] i_x,
    input  logic [adsrg_pkg::VAL_W-1:0] i_g,
    input  logic [adsrg_pkg::REG_W-1:0] i_coef,
    output logic [adsrg_pkg::VAL_W-1:0] o_y
);

    localparam int VW = adsrg_pkg::VAL_W;
    localparam int PW = adsrg_pkg::PROD_W;
    localparam logic [PW-1:0] ROUND = PW'(1) << (adsrg_pkg::COEF_FRAC_BITS - 1);

    logic          w_up;
    logic [VW-1:0] w_dist;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_step_full;
    logic [VW-1:0] w_step;

    assign w_up        = i_g > i_x;
    assign w_dist      = w_up ? (i_g - i_x) : (i_x - i_g);
    assign w_prod      = PW'(i_coef) * PW'(w_dist);
    assign w_step_full = (w_prod + ROUND) >> adsrg_pkg::COEF_FRAC_BITS;
    // The step never carries the value past its goal.
    assign w_step      = (w_step_full > PW'(w_dist)) ? w_dist : w_step_full[VW-1:0];
    assign o_y         = w_up ? (i_x + w_step) : (i_x - w_step);

endmodule

// ===== rtl/core/adsrg_core.sv =====
// Next-state logic of one voice: envelope stage update and pitch glide for one item.
// Depends on adsrg_pkg and adsrg_approach.
module adsrg_core (
    input  adsrg_pkg::t_cfg                 i_cfg,
    input  adsrg_pkg::t_voice               i_voice,
    input  logic [adsrg_pkg::OP_W-1:0]      i_op,
    input  logic [adsrg_pkg::FREQ_W-1:0]    i_target_freq,
    output adsrg_pkg::t_voice               o_voice
);

    localparam int VW = adsrg_pkg::VAL_W;
    localparam int AW = adsrg_pkg::AMP_W;
    localparam int FW = adsrg_pkg::FREQ_W;

    logic [VW-1:0]   w_amp;
    logic [VW-1:0]   w_sus;
    logic [VW-1:0]   w_env_goal;
    logic [VW-1:0]   w_env_y;
    logic [VW-1:0]   w_glide_y;
    logic [adsrg_pkg::REG_W-1:0] w_env_coef;
    logic [VW:0]     w_attack_sum;
    logic            w_attack_full;
    logic            w_decay_snap;
    logic            w_release_quiet;
    logic            w_amp_quiet;
    logic            w_amp_low;

    assign w_amp = VW'(i_voice.amp);
    // A sustain level above 1.0 counts as 1.0.
    assign w_sus = (VW'(i_cfg.sustain_level) > adsrg_pkg::AMP_ONE) ?
                   adsrg_pkg::AMP_ONE : VW'(i_cfg.sustain_level);

    assign w_env_goal = (i_voice.stage == adsrg_pkg::ST_DECAY) ? w_sus : '0;
    assign w_env_coef = (i_voice.stage == adsrg_pkg::ST_DECAY) ?
                        i_cfg.decay_coef : i_cfg.release_coef;

    adsrg_approach u_env (
        .i_x    (w_amp),
        .i_g    (w_env_goal),
        .i_coef (w_env_coef),
        .o_y    (w_env_y)
    );

    adsrg_approach u_glide (
        .i_x    (VW'(i_voice.freq_now)),
        .i_g    (VW'(i_voice.freq_goal)),
        .i_coef (i_cfg.pitch_rate),
        .o_y    (w_glide_y)
    );

    assign w_attack_sum    = {1'b0, w_amp} + {1'b0, VW'(i_cfg.attack_step)};
    assign w_attack_full   = w_attack_sum >= {1'b0, adsrg_pkg::AMP_ONE};
    assign w_decay_snap    = {1'b0, w_env_y} <= ({1'b0, w_sus} + {1'b0, adsrg_pkg::THR_SNAP});
    assign w_release_quiet = w_env_y < adsrg_pkg::THR_QUIET;
    assign w_amp_quiet     = w_amp < adsrg_pkg::THR_QUIET;
    assign w_amp_low       = w_amp < adsrg_pkg::THR_SNAP;

    always_comb begin
        o_voice = i_voice;
        case (i_op)
            adsrg_pkg::OP_TICK: begin
                // A silent idle voice stays frozen.
                if (!(i_voice.stage == adsrg_pkg::ST_IDLE && w_amp_quiet)) begin
                    o_voice.freq_now = w_glide_y[FW-1:0];
                    case (i_voice.stage)
                        adsrg_pkg::ST_ATTACK: begin
                            if (w_attack_full) begin
                                o_voice.amp   = adsrg_pkg::AMP_ONE[AW-1:0];
                                o_voice.stage = adsrg_pkg::ST_DECAY;
                            end else begin
                                o_voice.amp = w_attack_sum[AW-1:0];
                            end
                        end
                        adsrg_pkg::ST_DECAY: begin
                            if (w_decay_snap) begin
                                o_voice.amp   = w_sus[AW-1:0];
                                o_voice.stage = adsrg_pkg::ST_SUSTAIN;
                            end else begin
                                o_voice.amp = w_env_y[AW-1:0];
                            end
                        end
                        adsrg_pkg::ST_RELEASE: begin
                            if (w_release_quiet) begin
                                o_voice.amp   = '0;
                                o_voice.stage = adsrg_pkg::ST_IDLE;
                            end else begin
                                o_voice.amp = w_env_y[AW-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            adsrg_pkg::OP_NOTE_ON: begin
                if (i_voice.stage == adsrg_pkg::ST_IDLE || w_amp_low) begin
                    o_voice.freq_now = i_target_freq;
                end
                o_voice.freq_goal = i_target_freq;
                o_voice.stage     = adsrg_pkg::ST_ATTACK;
            end
            adsrg_pkg::OP_NOTE_OFF: begin
                if (i_voice.stage != adsrg_pkg::ST_IDLE) begin
                    o_voice.stage = adsrg_pkg::ST_RELEASE;
                end
            end
            default: begin
                // Panic.
                o_voice.amp   = '0;
                o_voice.stage = adsrg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/adsr_envelope_with_glide_unit.sv =====
// Top level of the ADSR envelope with glide unit: stream ports, register file,
// voice state and pipeline registers. Depends on adsrg_pkg and adsrg_core.

// One voice of an ADSR envelope with exponential pitch glide. Each input item
// is a sample tick, a note-on with a target frequency (1/256 Hz), a note-off
// or a panic, selected by the two-bit kind on i_s_tuser; every item yields
// exactly one result item carrying amplitude (Q1.23), glided frequency and
// stage. The block takes one item per clock cycle unless the result stream stalls.
// Accepting an item loads the input register; the voice state and the result
// register then load through the next-state logic (two 24 x 24 bit multiply,
// round and saturate paths, one for the envelope and one for the glide) once
// the result register is free or being emptied. The voice state is loaded
// together with the result, so back-to-back items always see the state left by
// the one before. A stalled output holds its result while one further item waits
// in the input register. Configuration registers are written through the plain
// write port and must only be changed while no item is in flight.
module adsr_envelope_with_glide_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata, from bit 0: target_freq[21:0], then zero fill.
    input  logic [adsrg_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // tuser, from bit 0: op[1:0].
    input  logic [adsrg_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // Result stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata, from bit 0: amplitude[23:0], frequency[21:0], stage[2:0], zero fill.
    output logic [adsrg_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [adsrg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [adsrg_pkg::REG_W-1:0]        i_cfg_data
);

    localparam int FW = adsrg_pkg::FREQ_W;
    localparam int MW = adsrg_pkg::M_TDATA_W;
    localparam int PAD_W = MW - adsrg_pkg::M_FIELD_W;

    adsrg_pkg::t_cfg   r_cfg;
    adsrg_pkg::t_voice r_voice;
    adsrg_pkg::t_voice n_voice;

    logic                          r_in_valid;
    logic [adsrg_pkg::OP_W-1:0]    r_in_op;
    logic [FW-1:0]                 r_in_freq;
    logic                          r_out_valid;
    logic [MW-1:0]                 r_out_data;
    logic                          w_advance;

    // The input register moves on whenever the result register is free or
    // being emptied in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Register file. Writes beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= adsrg_pkg::RST_ATTACK_STEP;
            r_cfg.decay_coef    <= adsrg_pkg::RST_DECAY_COEF;
            r_cfg.sustain_level <= adsrg_pkg::RST_SUSTAIN;
            r_cfg.release_coef  <= adsrg_pkg::RST_RELEASE;
            r_cfg.pitch_rate    <= adsrg_pkg::RST_PITCH_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adsrg_pkg::REG_ATTACK_STEP: r_cfg.attack_step   <= i_cfg_data;
                adsrg_pkg::REG_DECAY_COEF:  r_cfg.decay_coef    <= i_cfg_data;
                adsrg_pkg::REG_SUSTAIN:     r_cfg.sustain_level <= i_cfg_data;
                adsrg_pkg::REG_RELEASE:     r_cfg.release_coef  <= i_cfg_data;
                adsrg_pkg::REG_PITCH_RATE:  r_cfg.pitch_rate    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_op   <= i_s_tuser;
            r_in_freq <= i_s_tdata[FW-1:0];
        end
    end

    adsrg_core u_core (
        .i_cfg         (r_cfg),
        .i_voice       (r_voice),
        .i_op          (r_in_op),
        .i_target_freq (r_in_freq),
        .o_voice       (n_voice)
    );

    // Voice state, committed together with the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice.amp       <= '0;
            r_voice.freq_now  <= adsrg_pkg::RESET_FREQ;
            r_voice.freq_goal <= adsrg_pkg::RESET_FREQ;
            r_voice.stage     <= adsrg_pkg::ST_IDLE;
        end else if (w_advance) begin
            r_voice <= n_voice;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {{PAD_W{1'b0}}, n_voice.stage, n_voice.freq_now,
                           adsrg_pkg::OUT_AMP_W'(n_voice.amp)};
        end
    end

endmodule

// ===== rtl/core/adsrg_checker.sv =====
// Port-level checker for the ADSR envelope with glide unit, bound to the top level.
// Depends on adsrg_pkg and adsr_envelope_with_glide_unit_macros.svh.
`include "adsr_envelope_with_glide_unit_macros.svh"

module adsrg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [adsrg_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // A held result keeps its value until it is taken.
    `ADSRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // The input side only stalls when a result is waiting and stalled.
    `ADSRG_ASSERT_IMPL(a_in_stall_cause, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)

    // Amplitude never exceeds 1.0.
    `ADSRG_ASSERT_IMPL(a_amp_max, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[23:0] <= adsrg_pkg::AMP_ONE)

    // An idle voice is silent.
    `ADSRG_ASSERT_IMPL(a_idle_silent, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[48:46] == adsrg_pkg::ST_IDLE), o_m_tdata[23:0] == 24'd0)

endmodule

bind adsr_envelope_with_glide_unit adsrg_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
